FILE: hdl/assert_macros.svh
// Assertion macros for the B-spline cost and gradient core.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BTCG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("btcg assertion failed");

// next-cycle implication
`define BTCG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("btcg assertion failed");

`endif

FILE: hdl/btcg_pkg.sv
// Shared types, constants and sequencer states of the B-spline cost core.
// Used by btcg_cell, btcg_mul and bspline_trajectory_cost_gradient_core.
package btcg_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS);
    localparam int NUM_CELLS  = 4;
    localparam int NUM_AX     = 3;
    localparam int POS_W      = 32;
    localparam int GRAD_W     = 64;
    localparam int DIFF_W     = 36;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 192;
    localparam int M_TDATA_W  = 272;

    localparam logic [CFG_IDX_W-1:0] CFG_TERM_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SMOOTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FEAS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GUIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_INTERVAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL_SQ     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC_SQ     = 3'd6;

    typedef logic [NUM_AX-1:0][POS_W-1:0]  pos_vec_t;
    typedef logic [NUM_AX-1:0][GRAD_W-1:0] grad_vec_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32
    } mul_shift_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
        logic add_en;
        logic add_neg;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]        ax;
        logic [GRAD_W-1:0] mag;
    } add_bus_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INV4,
        ST_G_SQ, ST_G_CW, ST_G_GR,
        ST_V_SQ, ST_V_SC, ST_V_Q, ST_V_G, ST_V_C, ST_V_CW, ST_V_GR,
        ST_A_SQ, ST_A_SC, ST_A_Q, ST_A_G, ST_A_C, ST_A_CW, ST_A_GR1, ST_A_GR2,
        ST_J_SQ, ST_J_CW, ST_J_GR1, ST_J_GR3,
        ST_AX_END,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

FILE: hdl/btcg_cell.sv
// One window cell: a control point and its three gradient accumulators.
// Depends on btcg_pkg; cells pass their contents to the lower neighbor on shift.
module btcg_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  btcg_pkg::cell_ctl_t ctl,
    input  btcg_pkg::add_bus_t  bus,
    input  btcg_pkg::pos_vec_t  load_pos,
    input  btcg_pkg::pos_vec_t  nbr_pos,
    input  btcg_pkg::grad_vec_t nbr_grad,
    output btcg_pkg::pos_vec_t  pos,
    output btcg_pkg::grad_vec_t grad
);

    btcg_pkg::pos_vec_t  pos_reg;
    btcg_pkg::grad_vec_t grad_reg;
    btcg_pkg::grad_vec_t grad_next;
    logic signed [btcg_pkg::GRAD_W-1:0] addend;
    logic signed [btcg_pkg::GRAD_W:0]   sum [btcg_pkg::NUM_AX];

    // magnitude and sign to a saturated signed addend
    always_comb begin
        if (bus.mag[btcg_pkg::GRAD_W-1]) begin
            addend = ctl.add_neg ? {1'b1, {(btcg_pkg::GRAD_W-1){1'b0}}}
                                 : {1'b0, {(btcg_pkg::GRAD_W-1){1'b1}}};
        end else if (ctl.add_neg) begin
            addend = -$signed(bus.mag);
        end else begin
            addend = $signed(bus.mag);
        end
    end

    always_comb begin
        grad_next = grad_reg;
        for (int ax = 0; ax < btcg_pkg::NUM_AX; ax++) begin
            sum[ax] = $signed({grad_reg[ax][btcg_pkg::GRAD_W-1], grad_reg[ax]})
                    + $signed({addend[btcg_pkg::GRAD_W-1], addend});
            if (bus.ax == 2'(ax)) begin
                if (sum[ax][btcg_pkg::GRAD_W] != sum[ax][btcg_pkg::GRAD_W-1]) begin
                    grad_next[ax] = sum[ax][btcg_pkg::GRAD_W]
                        ? {1'b1, {(btcg_pkg::GRAD_W-1){1'b0}}}
                        : {1'b0, {(btcg_pkg::GRAD_W-1){1'b1}}};
                end else begin
                    grad_next[ax] = sum[ax][btcg_pkg::GRAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            pos_reg  <= '0;
            grad_reg <= '0;
        end else if (ctl.shift) begin
            pos_reg  <= nbr_pos;
            grad_reg <= nbr_grad;
        end else begin
            if (ctl.load) begin
                pos_reg <= load_pos;
            end
            if (ctl.add_en) begin
                grad_reg <= grad_next;
            end
        end
    end

    assign pos  = pos_reg;
    assign grad = grad_reg;

endmodule

FILE: hdl/btcg_mul.sv
// Iterative 64x64 multiplier: one 32x32 partial product per cycle, then a
// right shift by 0, 16 or 32 with saturation to 64 bits. Depends on btcg_pkg.
module btcg_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [btcg_pkg::GRAD_W-1:0] a,
    input  logic [btcg_pkg::GRAD_W-1:0] b,
    input  btcg_pkg::mul_shift_t        sh,
    output logic                        done,
    output logic [btcg_pkg::GRAD_W-1:0] res
);

    logic [63:0]          a_reg;
    logic [63:0]          b_reg;
    btcg_pkg::mul_shift_t sh_reg;
    logic [127:0]         acc_reg;
    logic [1:0]           step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [31:0]          a_part;
    logic [31:0]          b_part;
    logic [63:0]          pp;
    logic [1:0]           pos_sum;
    logic [127:0]         pp_sh;

    assign a_part  = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part  = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp      = a_part * b_part;
    assign pos_sum = {step_reg[1] & step_reg[0], step_reg[1] ^ step_reg[0]};
    assign pp_sh   = 128'(pp) << {pos_sum, 5'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            sh_reg  <= sh;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    always_comb begin
        case (sh_reg)
            btcg_pkg::SH_0:  res = (acc_reg[127:64] != '0) ? '1 : acc_reg[63:0];
            btcg_pkg::SH_16: res = (acc_reg[127:80] != '0) ? '1 : acc_reg[79:16];
            btcg_pkg::SH_32: res = (acc_reg[127:96] != '0) ? '1 : acc_reg[95:32];
            default:         res = '1;
        endcase
    end

    assign done = done_reg;

endmodule

FILE: hdl/bspline_trajectory_cost_gradient_core.sv
// Cubic B-spline jerk, feasibility and guide cost with gradients, streamed.
// Every product runs through one shared 32x32 multiplier as four partial
// products (up to 22 products per axis, three axes in turn); results leave
// through an output register.
// Reset (aresetn low, synchronous) clears the window, cost and count and loads
// the register defaults: term_enable 3, all other registers 65536.
`include "assert_macros.svh"

module bspline_trajectory_cost_gradient_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, guide_x, guide_y, guide_z
    input  logic [btcg_pkg::S_TDATA_W-1:0]   s_tdata,
    // guide_active
    input  logic [0:0]                       s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // grad_x, grad_y, grad_z, point_index, total_cost, zero pad
    output logic [btcg_pkg::M_TDATA_W-1:0]   m_tdata,
    // cost_valid
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int GW = btcg_pkg::GRAD_W;
    localparam int DW = btcg_pkg::DIFF_W;
    localparam int NC = btcg_pkg::NUM_CELLS;

    // configuration
    logic [2:0]  term_en_reg;
    logic [31:0] w_smooth_reg;
    logic [31:0] w_feas_reg;
    logic [31:0] w_guide_reg;
    logic [31:0] inv_reg;
    logic [31:0] vmax_reg;
    logic [31:0] amax_reg;

    btcg_pkg::state_t state_reg, state_next;
    logic [1:0]                 ax_reg;
    logic [1:0]                 k_reg;
    logic [btcg_pkg::CNT_W-1:0] cnt_reg;
    logic                       fin_reg;
    logic                       gact_reg;
    btcg_pkg::pos_vec_t         guide_reg;
    logic                       mul_wait_reg;
    logic [GW-1:0]              cost_reg;
    logic [GW-1:0]              inv4_reg;
    logic [GW-1:0]              r1_reg;
    logic [GW-1:0]              vd_reg;
    logic [GW-1:0]              g_reg;

    logic                          m_valid_reg;
    btcg_pkg::grad_vec_t           out_grad_reg;
    logic [btcg_pkg::IDX_W-1:0]    out_idx_reg;
    logic [GW-1:0]                 out_cost_reg;
    logic                          out_last_reg;

    // cell row
    btcg_pkg::cell_ctl_t cell_ctl  [NC];
    btcg_pkg::pos_vec_t  cell_pos  [NC];
    btcg_pkg::grad_vec_t cell_grad [NC];
    btcg_pkg::add_bus_t  add_bus;
    btcg_pkg::pos_vec_t  load_pos;

    // multiplier
    logic                 mul_start;
    logic [GW-1:0]        mul_a;
    logic [GW-1:0]        mul_b;
    btcg_pkg::mul_shift_t mul_sh;
    logic                 mul_done;
    logic [GW-1:0]        mul_res;

    // term selection
    logic g_on, v_on, a_on, j_on;
    logic n_ge1, n_ge2, n_ge3;
    btcg_pkg::state_t start_ax, after_g, after_v, after_a;
    logic is_mul_state;

    // differences
    logic signed [DW-1:0] cur_s, gd_s, p2_s, p1_s, p0_s;
    logic signed [DW-1:0] e_d, v_d, a_d, j_d, diff;
    logic [DW-1:0]        mag;
    logic                 sgn;
    logic [GW-1:0]        mag64;
    logic [GW-1:0]        vlim, alim;

    logic                  out_free;
    logic                  emit_ok;
    logic                  emit_fire;
    logic                  emit_final;
    logic [btcg_pkg::CNT_W:0] nk_sum;
    logic [31:0]           idx_full;
    logic [GW:0]           cost_sum;

    assign load_pos = btcg_pkg::pos_vec_t'(s_tdata[95:0]);

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_cell
            if (gi < NC - 1) begin : g_mid
                btcg_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctl      (cell_ctl[gi]),
                    .bus      (add_bus),
                    .load_pos (load_pos),
                    .nbr_pos  (cell_pos[gi+1]),
                    .nbr_grad (cell_grad[gi+1]),
                    .pos      (cell_pos[gi]),
                    .grad     (cell_grad[gi])
                );
            end else begin : g_top
                btcg_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctl      (cell_ctl[gi]),
                    .bus      (add_bus),
                    .load_pos (load_pos),
                    .nbr_pos  ('0),
                    .nbr_grad ('0),
                    .pos      (cell_pos[gi]),
                    .grad     (cell_grad[gi])
                );
            end
        end
    endgenerate

    btcg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .sh      (mul_sh),
        .done    (mul_done),
        .res     (mul_res)
    );

    // ---- differences of the current axis ----
    assign cur_s = DW'($signed(cell_pos[3][ax_reg]));
    assign p2_s  = DW'($signed(cell_pos[2][ax_reg]));
    assign p1_s  = DW'($signed(cell_pos[1][ax_reg]));
    assign p0_s  = DW'($signed(cell_pos[0][ax_reg]));
    assign gd_s  = DW'($signed(guide_reg[ax_reg]));
    assign e_d   = cur_s - gd_s;
    assign v_d   = cur_s - p2_s;
    assign a_d   = cur_s - (p2_s <<< 1) + p1_s;
    assign j_d   = cur_s - (p2_s + (p2_s <<< 1)) + (p1_s + (p1_s <<< 1)) - p0_s;

    always_comb begin
        case (state_reg)
            btcg_pkg::ST_V_SQ, btcg_pkg::ST_V_SC, btcg_pkg::ST_V_Q, btcg_pkg::ST_V_G,
            btcg_pkg::ST_V_C, btcg_pkg::ST_V_CW, btcg_pkg::ST_V_GR: diff = v_d;
            btcg_pkg::ST_A_SQ, btcg_pkg::ST_A_SC, btcg_pkg::ST_A_Q, btcg_pkg::ST_A_G,
            btcg_pkg::ST_A_C, btcg_pkg::ST_A_CW, btcg_pkg::ST_A_GR1,
            btcg_pkg::ST_A_GR2: diff = a_d;
            btcg_pkg::ST_J_SQ, btcg_pkg::ST_J_CW, btcg_pkg::ST_J_GR1,
            btcg_pkg::ST_J_GR3: diff = j_d;
            default: diff = e_d;
        endcase
    end

    assign sgn   = diff[DW-1];
    assign mag   = sgn ? DW'(-diff) : DW'(diff);
    assign mag64 = GW'(mag);
    assign vlim  = {16'b0, vmax_reg, 16'b0};
    assign alim  = {16'b0, amax_reg, 16'b0};

    // ---- term selection ----
    assign n_ge1 = (cnt_reg >= btcg_pkg::CNT_W'(1));
    assign n_ge2 = (cnt_reg >= btcg_pkg::CNT_W'(2));
    assign n_ge3 = (cnt_reg >= btcg_pkg::CNT_W'(3));
    assign g_on  = term_en_reg[2] && gact_reg;
    assign v_on  = term_en_reg[1] && n_ge1;
    assign a_on  = term_en_reg[1] && n_ge2;
    assign j_on  = term_en_reg[0] && n_ge3;
    assign after_a  = j_on ? btcg_pkg::ST_J_SQ : btcg_pkg::ST_AX_END;
    assign after_v  = a_on ? btcg_pkg::ST_A_SQ : after_a;
    assign after_g  = v_on ? btcg_pkg::ST_V_SQ : after_v;
    assign start_ax = g_on ? btcg_pkg::ST_G_SQ : after_g;

    // ---- emission ----
    assign out_free   = !m_valid_reg || m_tready;
    assign nk_sum     = (btcg_pkg::CNT_W+1)'(cnt_reg) + (btcg_pkg::CNT_W+1)'(k_reg);
    assign emit_ok    = (nk_sum >= (btcg_pkg::CNT_W+1)'(3));
    assign emit_final = (state_reg == btcg_pkg::ST_FLUSH) && (k_reg == 2'd3);
    assign idx_full   = 32'(cnt_reg) + 32'(k_reg) - 32'd3;
    assign cost_sum   = {1'b0, cost_reg} + {1'b0, mul_res};

    always_comb begin
        case (state_reg)
            btcg_pkg::ST_IDLE, btcg_pkg::ST_AX_END, btcg_pkg::ST_EMIT,
            btcg_pkg::ST_FLUSH: is_mul_state = 1'b0;
            default:           is_mul_state = 1'b1;
        endcase
    end

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            btcg_pkg::ST_IDLE:  if (s_tvalid) state_next = btcg_pkg::ST_INV4;
            btcg_pkg::ST_INV4:  if (mul_done) state_next = start_ax;
            btcg_pkg::ST_G_SQ:  if (mul_done) state_next = btcg_pkg::ST_G_CW;
            btcg_pkg::ST_G_CW:  if (mul_done) state_next = btcg_pkg::ST_G_GR;
            btcg_pkg::ST_G_GR:  if (mul_done) state_next = after_g;
            btcg_pkg::ST_V_SQ:  if (mul_done) state_next = btcg_pkg::ST_V_SC;
            btcg_pkg::ST_V_SC: begin
                if (mul_done) state_next = (mul_res > vlim) ? btcg_pkg::ST_V_Q : after_v;
            end
            btcg_pkg::ST_V_Q:   if (mul_done) state_next = btcg_pkg::ST_V_G;
            btcg_pkg::ST_V_G:   if (mul_done) state_next = btcg_pkg::ST_V_C;
            btcg_pkg::ST_V_C:   if (mul_done) state_next = btcg_pkg::ST_V_CW;
            btcg_pkg::ST_V_CW:  if (mul_done) state_next = btcg_pkg::ST_V_GR;
            btcg_pkg::ST_V_GR:  if (mul_done) state_next = after_v;
            btcg_pkg::ST_A_SQ:  if (mul_done) state_next = btcg_pkg::ST_A_SC;
            btcg_pkg::ST_A_SC: begin
                if (mul_done) state_next = (mul_res > alim) ? btcg_pkg::ST_A_Q : after_a;
            end
            btcg_pkg::ST_A_Q:   if (mul_done) state_next = btcg_pkg::ST_A_G;
            btcg_pkg::ST_A_G:   if (mul_done) state_next = btcg_pkg::ST_A_C;
            btcg_pkg::ST_A_C:   if (mul_done) state_next = btcg_pkg::ST_A_CW;
            btcg_pkg::ST_A_CW:  if (mul_done) state_next = btcg_pkg::ST_A_GR1;
            btcg_pkg::ST_A_GR1: if (mul_done) state_next = btcg_pkg::ST_A_GR2;
            btcg_pkg::ST_A_GR2: if (mul_done) state_next = after_a;
            btcg_pkg::ST_J_SQ:  if (mul_done) state_next = btcg_pkg::ST_J_CW;
            btcg_pkg::ST_J_CW:  if (mul_done) state_next = btcg_pkg::ST_J_GR1;
            btcg_pkg::ST_J_GR1: if (mul_done) state_next = btcg_pkg::ST_J_GR3;
            btcg_pkg::ST_J_GR3: if (mul_done) state_next = btcg_pkg::ST_AX_END;
            btcg_pkg::ST_AX_END: begin
                if (ax_reg == 2'd2) begin
                    state_next = fin_reg ? btcg_pkg::ST_FLUSH : btcg_pkg::ST_EMIT;
                end else begin
                    state_next = start_ax;
                end
            end
            btcg_pkg::ST_EMIT: begin
                if (!emit_ok || out_free) state_next = btcg_pkg::ST_IDLE;
            end
            btcg_pkg::ST_FLUSH: begin
                if ((!emit_ok || out_free) && k_reg == 2'd3) state_next = btcg_pkg::ST_IDLE;
            end
            default: state_next = btcg_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        mul_start = is_mul_state && !mul_wait_reg;
        mul_a     = mag64;
        mul_b     = mag64;
        mul_sh    = btcg_pkg::SH_0;
        add_bus.ax  = ax_reg;
        add_bus.mag = mul_res;
        emit_fire = 1'b0;
        for (int c = 0; c < NC; c++) begin
            cell_ctl[c] = '0;
        end
        case (state_reg)
            btcg_pkg::ST_IDLE: begin
                cell_ctl[3].load = s_tvalid;
            end
            btcg_pkg::ST_INV4: begin
                mul_a = GW'(inv_reg);
                mul_b = GW'(inv_reg);
            end
            btcg_pkg::ST_G_CW: begin
                mul_a = r1_reg;  mul_b = GW'(w_guide_reg); mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_G_GR: begin
                mul_a = mag64 << 17; mul_b = GW'(w_guide_reg); mul_sh = btcg_pkg::SH_16;
                cell_ctl[3].add_en  = mul_done;
                cell_ctl[3].add_neg = sgn;
            end
            btcg_pkg::ST_V_SC: begin
                mul_a = r1_reg;  mul_b = GW'(inv_reg); mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_V_Q: begin
                mul_a = vd_reg;  mul_b = GW'(inv_reg); mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_V_G, btcg_pkg::ST_A_G: begin
                mul_a = r1_reg;  mul_b = mag64; mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_V_C, btcg_pkg::ST_A_C: begin
                mul_a = vd_reg;  mul_b = vd_reg; mul_sh = btcg_pkg::SH_32;
            end
            btcg_pkg::ST_V_CW, btcg_pkg::ST_A_CW: begin
                mul_a = r1_reg;  mul_b = GW'(w_feas_reg); mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_V_GR: begin
                mul_a = g_reg;   mul_b = GW'(w_feas_reg); mul_sh = btcg_pkg::SH_16;
                cell_ctl[2].add_en  = mul_done;
                cell_ctl[2].add_neg = !sgn;
                cell_ctl[3].add_en  = mul_done;
                cell_ctl[3].add_neg = sgn;
            end
            btcg_pkg::ST_A_SC: begin
                mul_a = r1_reg;  mul_b = inv4_reg; mul_sh = btcg_pkg::SH_32;
            end
            btcg_pkg::ST_A_Q: begin
                mul_a = vd_reg;  mul_b = inv4_reg; mul_sh = btcg_pkg::SH_32;
            end
            btcg_pkg::ST_A_GR1: begin
                mul_a = g_reg;   mul_b = GW'(w_feas_reg); mul_sh = btcg_pkg::SH_16;
                cell_ctl[1].add_en  = mul_done;
                cell_ctl[1].add_neg = sgn;
                cell_ctl[3].add_en  = mul_done;
                cell_ctl[3].add_neg = sgn;
            end
            btcg_pkg::ST_A_GR2: begin
                // doubled slope, saturated
                mul_a  = g_reg[GW-1] ? '1 : (g_reg << 1);
                mul_b  = GW'(w_feas_reg);
                mul_sh = btcg_pkg::SH_16;
                cell_ctl[2].add_en  = mul_done;
                cell_ctl[2].add_neg = !sgn;
            end
            btcg_pkg::ST_J_CW: begin
                mul_a = r1_reg;  mul_b = GW'(w_smooth_reg); mul_sh = btcg_pkg::SH_16;
            end
            btcg_pkg::ST_J_GR1: begin
                mul_a = mag64 << 17; mul_b = GW'(w_smooth_reg); mul_sh = btcg_pkg::SH_16;
                cell_ctl[0].add_en  = mul_done;
                cell_ctl[0].add_neg = !sgn;
                cell_ctl[3].add_en  = mul_done;
                cell_ctl[3].add_neg = sgn;
            end
            btcg_pkg::ST_J_GR3: begin
                mul_a  = (mag64 << 17) + (mag64 << 18);
                mul_b  = GW'(w_smooth_reg);
                mul_sh = btcg_pkg::SH_16;
                cell_ctl[1].add_en  = mul_done;
                cell_ctl[1].add_neg = sgn;
                cell_ctl[2].add_en  = mul_done;
                cell_ctl[2].add_neg = !sgn;
            end
            btcg_pkg::ST_EMIT, btcg_pkg::ST_FLUSH: begin
                emit_fire = emit_ok && out_free;
                // advance the row, or clear it after the final point, once the oldest point is out or skipped
                if (!emit_ok || out_free) begin
                    for (int c = 0; c < NC; c++) begin
                        cell_ctl[c].shift = !emit_final;
                        cell_ctl[c].clear = emit_final;
                    end
                end
            end
            default: ;
        endcase
    end

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= btcg_pkg::ST_IDLE;
            mul_wait_reg <= 1'b0;
            ax_reg       <= '0;
            k_reg        <= '0;
            cnt_reg      <= '0;
            cost_reg     <= '0;
            fin_reg      <= 1'b0;
            gact_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start) begin
                mul_wait_reg <= 1'b1;
            end else if (mul_done) begin
                mul_wait_reg <= 1'b0;
            end
            case (state_reg)
                btcg_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        ax_reg   <= '0;
                        k_reg    <= '0;
                        gact_reg <= s_tuser[0];
                        fin_reg  <= s_tlast ||
                                    (cnt_reg == btcg_pkg::CNT_W'(btcg_pkg::MAX_POINTS - 1));
                    end
                end
                btcg_pkg::ST_G_CW, btcg_pkg::ST_V_CW, btcg_pkg::ST_A_CW,
                btcg_pkg::ST_J_CW: begin
                    if (mul_done) begin
                        cost_reg <= cost_sum[GW] ? '1 : cost_sum[GW-1:0];
                    end
                end
                btcg_pkg::ST_AX_END: begin
                    if (ax_reg != 2'd2) ax_reg <= ax_reg + 2'd1;
                end
                btcg_pkg::ST_EMIT: begin
                    if (!emit_ok || out_free) cnt_reg <= cnt_reg + btcg_pkg::CNT_W'(1);
                end
                btcg_pkg::ST_FLUSH: begin
                    if (!emit_ok || out_free) begin
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd3) begin
                            cnt_reg  <= '0;
                            cost_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // multiplier temporaries
    always_ff @(posedge aclk) begin
        if (mul_done) begin
            case (state_reg)
                btcg_pkg::ST_INV4: inv4_reg <= mul_res;
                btcg_pkg::ST_G_SQ, btcg_pkg::ST_V_SQ, btcg_pkg::ST_A_SQ, btcg_pkg::ST_J_SQ,
                btcg_pkg::ST_V_C, btcg_pkg::ST_A_C: r1_reg <= mul_res;
                btcg_pkg::ST_V_SC: vd_reg <= mul_res - vlim;
                btcg_pkg::ST_A_SC: vd_reg <= mul_res - alim;
                btcg_pkg::ST_V_Q, btcg_pkg::ST_A_Q: begin
                    r1_reg <= (mul_res[GW-1:GW-2] != 2'b00) ? '1 : (mul_res << 2);
                end
                btcg_pkg::ST_V_G, btcg_pkg::ST_A_G: g_reg <= mul_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_en_reg  <= 3'd3;
            w_smooth_reg <= 32'd65536;
            w_feas_reg   <= 32'd65536;
            w_guide_reg  <= 32'd65536;
            inv_reg      <= 32'd65536;
            vmax_reg     <= 32'd65536;
            amax_reg     <= 32'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                btcg_pkg::CFG_TERM_ENABLE:   term_en_reg  <= cfg_data[2:0];
                btcg_pkg::CFG_WEIGHT_SMOOTH: w_smooth_reg <= cfg_data;
                btcg_pkg::CFG_WEIGHT_FEAS:   w_feas_reg   <= cfg_data;
                btcg_pkg::CFG_WEIGHT_GUIDE:  w_guide_reg  <= cfg_data;
                btcg_pkg::CFG_INV_INTERVAL:  inv_reg      <= cfg_data;
                btcg_pkg::CFG_MAX_VEL_SQ:    vmax_reg     <= cfg_data;
                btcg_pkg::CFG_MAX_ACC_SQ:    amax_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            guide_reg <= btcg_pkg::pos_vec_t'(s_tdata[191:96]);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            out_grad_reg <= cell_grad[0];
            out_idx_reg  <= idx_full[btcg_pkg::IDX_W-1:0];
            out_cost_reg <= emit_final ? cost_reg : '0;
            out_last_reg <= emit_final;
        end
    end

    assign s_tready  = (state_reg == btcg_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, out_cost_reg, out_idx_reg, out_grad_reg};
    assign m_tuser   = out_last_reg;
    assign m_tlast   = out_last_reg;

    `BTCG_ASSERT_IMP(a_done_owned, mul_done, mul_wait_reg)
    `BTCG_ASSERT_IMP(a_idle_no_mul, s_tready, !mul_wait_reg)
    `BTCG_ASSERT_IMP(a_cost_on_last, m_tvalid && m_tuser[0], m_tlast)
    `BTCG_ASSERT_NXT(a_one_point, s_tvalid && s_tready, !s_tready)

endmodule
